>>> design/tft_command_window_writer_assert.svh
// Assertion macros used by the decoder module.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TFT_COMMAND_WINDOW_WRITER_ASSERT_SVH
`define TFT_COMMAND_WINDOW_WRITER_ASSERT_SVH

// Whenever cond holds, prop must hold in the same cycle.
`define TFTCWW_ASSERT_SAME(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("same-cycle assertion failed");

// Whenever cond holds, prop must hold in the following cycle.
`define TFTCWW_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle assertion failed");

`endif

>>> design/tftcww_pkg.sv
package tftcww_pkg;

  localparam int BYTE_W   = 8;
  localparam int PTR_W    = 16;
  localparam int COLUMN_W = 8;
  localparam int ROW_W    = 9;
  localparam int COLOR_W  = 16;
  localparam int INDEX_W  = 3;

  localparam int DEFAULT_COLUMNS = 240;
  localparam int DEFAULT_ROWS    = 320;

  localparam logic [BYTE_W-1:0] CMD_SLEEP_OUT    = 8'h11;
  localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON   = 8'h29;
  localparam logic [BYTE_W-1:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE = 8'h2C;
  localparam logic [BYTE_W-1:0] CMD_MADCTL       = 8'h36;
  localparam logic [BYTE_W-1:0] CMD_COLMOD       = 8'h3A;
  localparam logic [BYTE_W-1:0] CMD_NONE         = 8'h00;

  // Bit of the MADCTL parameter that selects BGR order.
  localparam int MADCTL_BGR_BIT = 3;

  // Number of data bytes taken by a column-set or row-set command.
  localparam logic [INDEX_W-1:0] WINDOW_BYTES = 3'd4;

  function automatic logic [COLOR_W-1:0] swap_red_blue_fn(input logic [COLOR_W-1:0] c);
    swap_red_blue_fn = {c[4:0], c[10:5], c[15:11]};
  endfunction

endpackage

>>> design/tftcww_if.sv
// Byte link from the host: one command or data byte per transaction.
interface tftcww_byte_if;
  import tftcww_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] byte_value;

  modport source(output valid, command, byte_value, input ready);
  modport sink(input valid, command, byte_value, output ready);
endinterface

// Result of one byte: the pixel write, if any, and the status flags.
interface tftcww_pixel_if;
  import tftcww_pkg::*;

  logic                valid;
  logic                ready;
  logic                write_valid;
  logic [COLUMN_W-1:0] column;
  logic [ROW_W-1:0]    row;
  logic [COLOR_W-1:0]  pixel_color;
  logic                awake;
  logic                display_enabled;

  modport source(output valid, write_valid, column, row, pixel_color, awake,
                 display_enabled, input ready);
  modport sink(input valid, write_valid, column, row, pixel_color, awake,
               display_enabled, output ready);
endinterface

>>> design/tft_command_window_writer.sv
// Channel  | Direction | Transaction carries
// ---------+-----------+------------------------------------------------------
// link     | in        | command flag and one byte from the serial link
// pixel    | out       | write_valid, column, row, pixel_color, awake,
//          |           | display_enabled: exactly one per accepted byte
//
// Each byte is decoded in the cycle it is accepted and its result appears in
// the output register on the next cycle.
// A new byte is accepted every cycle while the output register is empty or
// is being drained in the same cycle; throughput is one byte per cycle.
// A stall on the pixel channel holds the result and stops byte acceptance.
// Reset is synchronous and restores the full-panel window, clears the pointer
// and the status flags, and empties the output register.
module tft_command_window_writer #(
  parameter int COLUMNS = tftcww_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tftcww_pkg::DEFAULT_ROWS
) (
  input logic           clk,
  input logic           rst,
  tftcww_byte_if.sink   link,
  tftcww_pixel_if.source pixel
);
  import tftcww_pkg::*;

  // Limits of the frame memory, held in the width of the window registers.
  localparam logic [PTR_W-1:0] ColumnLimit = PTR_W'(COLUMNS);
  localparam logic [PTR_W-1:0] RowLimit    = PTR_W'(ROWS);
  localparam logic [PTR_W-1:0] ColumnLast  = PTR_W'(COLUMNS - 1);
  localparam logic [PTR_W-1:0] RowLast     = PTR_W'(ROWS - 1);

  // Decoder state, as seen by the byte currently on the link.
  logic [BYTE_W-1:0]  active_command,    active_command_next;
  logic [INDEX_W-1:0] parameter_index,   parameter_index_next;
  logic [PTR_W-1:0]   column_start,      column_start_next;
  logic [PTR_W-1:0]   column_end,        column_end_next;
  logic [PTR_W-1:0]   row_start,         row_start_next;
  logic [PTR_W-1:0]   row_end,           row_end_next;
  logic [PTR_W-1:0]   column_pointer,    column_pointer_next;
  logic [PTR_W-1:0]   row_pointer,       row_pointer_next;
  logic [BYTE_W-1:0]  pending_high_byte, pending_high_byte_next;
  logic               have_high_byte,    have_high_byte_next;
  logic               swap_red_blue,     swap_red_blue_next;
  logic               awake_flag,        awake_flag_next;
  logic               display_flag,      display_flag_next;

  // Result of the byte being accepted.
  logic               write_valid_next;
  logic [COLOR_W-1:0] pixel_color_next;
  logic [COLOR_W-1:0] raw_color;

  // Output register.
  logic                out_valid;
  logic                write_valid;
  logic [COLUMN_W-1:0] column;
  logic [ROW_W-1:0]    row;
  logic [COLOR_W-1:0]  pixel_color;
  logic                awake;
  logic                display_enabled;

  logic accept;

  // The output register frees up in the same cycle it is drained, so bytes
  // flow at full rate whenever the downstream side keeps taking results.
  assign link.ready = !out_valid || pixel.ready;
  assign accept     = link.valid && link.ready;

  assign raw_color = {pending_high_byte, link.byte_value};

  always_comb begin
    active_command_next    = active_command;
    parameter_index_next   = parameter_index;
    column_start_next      = column_start;
    column_end_next        = column_end;
    row_start_next         = row_start;
    row_end_next           = row_end;
    column_pointer_next    = column_pointer;
    row_pointer_next       = row_pointer;
    pending_high_byte_next = pending_high_byte;
    have_high_byte_next    = have_high_byte;
    swap_red_blue_next     = swap_red_blue;
    awake_flag_next        = awake_flag;
    display_flag_next      = display_flag;
    write_valid_next       = 1'b0;
    pixel_color_next       = swap_red_blue ? swap_red_blue_fn(raw_color) : raw_color;

    if (link.command) begin
      // A command byte restarts parameter counting and drops a half pixel.
      active_command_next  = link.byte_value;
      parameter_index_next = '0;
      have_high_byte_next  = 1'b0;
      case (link.byte_value)
        CMD_MEMORY_WRITE: begin
          column_pointer_next = column_start;
          row_pointer_next    = row_start;
        end
        CMD_SLEEP_OUT:  awake_flag_next   = 1'b1;
        CMD_DISPLAY_ON: display_flag_next = 1'b1;
        default: ;
      endcase
    end else begin
      case (active_command)
        CMD_COLUMN_SET, CMD_ROW_SET: begin
          // Big-endian start then end; bytes past the fourth are dropped.
          if (parameter_index < WINDOW_BYTES) begin
            parameter_index_next = parameter_index + 1'b1;
            if (active_command == CMD_COLUMN_SET) begin
              case (parameter_index[1:0])
                2'd0:    column_start_next[15:8] = link.byte_value;
                2'd1:    column_start_next[7:0]  = link.byte_value;
                2'd2:    column_end_next[15:8]   = link.byte_value;
                default: column_end_next[7:0]    = link.byte_value;
              endcase
            end else begin
              case (parameter_index[1:0])
                2'd0:    row_start_next[15:8] = link.byte_value;
                2'd1:    row_start_next[7:0]  = link.byte_value;
                2'd2:    row_end_next[15:8]   = link.byte_value;
                default: row_end_next[7:0]    = link.byte_value;
              endcase
            end
          end
        end
        CMD_MADCTL: begin
          // Only the first parameter byte carries the colour order.
          if (parameter_index == '0) begin
            swap_red_blue_next   = link.byte_value[MADCTL_BGR_BIT];
            parameter_index_next = INDEX_W'(1);
          end
        end
        CMD_MEMORY_WRITE: begin
          if (!have_high_byte) begin
            pending_high_byte_next = link.byte_value;
            have_high_byte_next    = 1'b1;
          end else begin
            have_high_byte_next = 1'b0;
            // Cells outside the frame memory are skipped, but the pointer
            // still moves on.
            write_valid_next = (column_pointer < ColumnLimit) &&
                               (row_pointer < RowLimit);
            if (column_pointer >= column_end) begin
              column_pointer_next = column_start;
              if (row_pointer >= row_end) begin
                row_pointer_next = row_start;
              end else begin
                row_pointer_next = row_pointer + 1'b1;
              end
            end else begin
              column_pointer_next = column_pointer + 1'b1;
            end
          end
        end
        // Pixel format bytes, unknown commands and stray data are ignored.
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_command    <= CMD_NONE;
      parameter_index   <= '0;
      column_start      <= '0;
      column_end        <= ColumnLast;
      row_start         <= '0;
      row_end           <= RowLast;
      column_pointer    <= '0;
      row_pointer       <= '0;
      pending_high_byte <= '0;
      have_high_byte    <= 1'b0;
      swap_red_blue     <= 1'b0;
      awake_flag        <= 1'b0;
      display_flag      <= 1'b0;
    end else if (accept) begin
      active_command    <= active_command_next;
      parameter_index   <= parameter_index_next;
      column_start      <= column_start_next;
      column_end        <= column_end_next;
      row_start         <= row_start_next;
      row_end           <= row_end_next;
      column_pointer    <= column_pointer_next;
      row_pointer       <= row_pointer_next;
      pending_high_byte <= pending_high_byte_next;
      have_high_byte    <= have_high_byte_next;
      swap_red_blue     <= swap_red_blue_next;
      awake_flag        <= awake_flag_next;
      display_flag      <= display_flag_next;
    end
  end

  // Output register: filled on every accepted byte, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  // The payload needs no reset; the address and colour read as zero when no
  // pixel was written.
  always_ff @(posedge clk) begin
    if (accept) begin
      write_valid     <= write_valid_next;
      column          <= write_valid_next ? column_pointer[COLUMN_W-1:0] : '0;
      row             <= write_valid_next ? row_pointer[ROW_W-1:0] : '0;
      pixel_color     <= write_valid_next ? pixel_color_next : '0;
      awake           <= awake_flag_next;
      display_enabled <= display_flag_next;
    end
  end

  assign pixel.valid           = out_valid;
  assign pixel.write_valid     = write_valid;
  assign pixel.column          = column;
  assign pixel.row             = row;
  assign pixel.pixel_color     = pixel_color;
  assign pixel.awake           = awake;
  assign pixel.display_enabled = display_enabled;

`include "tft_command_window_writer_assert.svh"

  // A half pixel only ever exists inside a memory-write.
  `TFTCWW_ASSERT_SAME(a_half_pixel_in_write, have_high_byte, active_command == CMD_MEMORY_WRITE)
  // The parameter counter never runs past the four window bytes.
  `TFTCWW_ASSERT_SAME(a_index_bounded, 1'b1, parameter_index <= WINDOW_BYTES)
  // A command byte always restarts parameter decoding.
  `TFTCWW_ASSERT_NEXT(a_command_restarts, accept && link.command,
                      parameter_index == '0 && !have_high_byte)
  // A stored pixel always lies inside the frame memory.
  `TFTCWW_ASSERT_SAME(a_write_in_memory, accept && write_valid_next,
                      column_pointer < ColumnLimit && row_pointer < RowLimit)
  // A sleep-out command is visible on the result of that very byte.
  `TFTCWW_ASSERT_NEXT(a_sleep_out_seen,
                      accept && link.command && link.byte_value == CMD_SLEEP_OUT,
                      out_valid && awake)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Stand-alone bench for the panel-side command/data byte decoder. Bytes go in
// on the link channel, and each accepted byte yields exactly one transaction
// on the pixel channel. A behavioural copy of the decoder runs alongside the
// stimulus. Its result for each accepted byte is queued, and the queue is
// compared in order with what the pixel channel delivers.
module tb_top;
  import tftcww_pkg::*;

  localparam int PANEL_COLUMNS = DEFAULT_COLUMNS;
  localparam int PANEL_ROWS    = DEFAULT_ROWS;

  // The random phase stops once roughly this many bytes have been accepted.
  localparam int RANDOM_BYTES = 1600;
  // Bounds the run so that a hang cannot go on for ever. Gaps and stalls on
  // each side, plus the long hold, keep a normal run well below this limit.
  localparam int CYCLE_LIMIT  = 200000;
  // The receiver holds ready low for this long, once, so that the output
  // register fills and the link channel stalls.
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 500;
  // After the queue empties, this many more cycles are allowed so that any
  // stray transaction can still be caught.
  localparam int SETTLE_CYCLES = 8;

  localparam logic AS_COMMAND = 1'b1;
  localparam logic AS_DATA    = 1'b0;

  typedef struct packed {
    logic                write_valid;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [COLOR_W-1:0]  pixel_color;
    logic                awake;
    logic                display_enabled;
  } pixel_result_t;

  // One row of the directed table. Where typed is set, the result is written
  // out by hand and is pushed in place of the predicted one.
  typedef struct packed {
    logic               command;
    logic [BYTE_W-1:0]  value;
    logic               typed;
    pixel_result_t      result;
  } link_row_t;

  localparam pixel_result_t IDLE_ASLEEP = '{1'b0, 8'd0, 9'd0, 16'h0000, 1'b0, 1'b0};
  localparam pixel_result_t IDLE_AWAKE  = '{1'b0, 8'd0, 9'd0, 16'h0000, 1'b1, 1'b0};
  localparam pixel_result_t IDLE_LIT    = '{1'b0, 8'd0, 9'd0, 16'h0000, 1'b1, 1'b1};

  localparam int DIRECTED_ROWS = 31;

  // The directed walk runs through these cases in turn:
  //  - data with no command, and an unknown command, leave everything at zero;
  //  - a full-panel memory write with all ones, then all zeros;
  //  - sleep-out, then display-on, each of which raises its flag;
  //  - a colour-mode byte, which is accepted and then ignored;
  //  - MADCTL with BGR set, which swaps the red and blue fields;
  //  - a column window from 239 to 256, with a fifth byte that is ignored;
  //  - a pixel on the last column, then one on column 240, which lies outside
  //    the memory and is therefore not stored;
  //  - a row window whose start (319) lies beyond its end (0), followed by a
  //    memory write that starts from that start row and leaves a half pixel
  //    for the random phase to complete.
  localparam link_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{AS_DATA,    8'hFF,            1'b1, IDLE_ASLEEP},
    '{AS_COMMAND, 8'hFF,            1'b1, IDLE_ASLEEP},
    '{AS_COMMAND, CMD_MEMORY_WRITE, 1'b1, IDLE_ASLEEP},
    '{AS_DATA,    8'hFF,            1'b1, IDLE_ASLEEP},
    '{AS_DATA,    8'hFF,            1'b1, '{1'b1, 8'd0, 9'd0, 16'hFFFF, 1'b0, 1'b0}},
    '{AS_DATA,    8'h00,            1'b0, IDLE_ASLEEP},
    '{AS_DATA,    8'h00,            1'b1, '{1'b1, 8'd1, 9'd0, 16'h0000, 1'b0, 1'b0}},
    '{AS_COMMAND, CMD_SLEEP_OUT,    1'b1, IDLE_AWAKE},
    '{AS_COMMAND, CMD_DISPLAY_ON,   1'b1, IDLE_LIT},
    '{AS_COMMAND, CMD_COLMOD,       1'b0, IDLE_LIT},
    '{AS_DATA,    8'h55,            1'b1, IDLE_LIT},
    '{AS_COMMAND, CMD_MADCTL,       1'b0, IDLE_LIT},
    '{AS_DATA,    8'h08,            1'b0, IDLE_LIT},
    '{AS_COMMAND, CMD_COLUMN_SET,   1'b0, IDLE_LIT},
    '{AS_DATA,    8'h00,            1'b0, IDLE_LIT},
    '{AS_DATA,    8'hEF,            1'b0, IDLE_LIT},
    '{AS_DATA,    8'h01,            1'b0, IDLE_LIT},
    '{AS_DATA,    8'h00,            1'b0, IDLE_LIT},
    '{AS_DATA,    8'h77,            1'b1, IDLE_LIT},
    '{AS_COMMAND, CMD_MEMORY_WRITE, 1'b0, IDLE_LIT},
    '{AS_DATA,    8'hF8,            1'b0, IDLE_LIT},
    '{AS_DATA,    8'h00,            1'b1, '{1'b1, 8'd239, 9'd0, 16'h001F, 1'b1, 1'b1}},
    '{AS_DATA,    8'h12,            1'b0, IDLE_LIT},
    '{AS_DATA,    8'h34,            1'b1, IDLE_LIT},
    '{AS_COMMAND, CMD_ROW_SET,      1'b0, IDLE_LIT},
    '{AS_DATA,    8'h01,            1'b0, IDLE_LIT},
    '{AS_DATA,    8'h3F,            1'b0, IDLE_LIT},
    '{AS_DATA,    8'h00,            1'b0, IDLE_LIT},
    '{AS_DATA,    8'h00,            1'b0, IDLE_LIT},
    '{AS_COMMAND, CMD_MEMORY_WRITE, 1'b0, IDLE_LIT},
    '{AS_DATA,    8'hAB,            1'b0, IDLE_LIT}
  };

  logic clk;
  logic rst;

  tftcww_byte_if  link();
  tftcww_pixel_if pixel();

  tft_command_window_writer dut (
    .clk   (clk),
    .rst   (rst),
    .link  (link),
    .pixel (pixel)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------
  // Decoder state as the bench sees it. Each window is held as one 32-bit
  // word {start, end}, so that the four big-endian parameter bytes fill it
  // from the most significant byte downwards.
  // ---------------------------------------------------------------------
  logic [BYTE_W-1:0]  current_command;
  logic [INDEX_W-1:0] parameters_taken;
  logic [31:0]        column_window;
  logic [31:0]        row_window;
  logic [PTR_W-1:0]   column_ptr;
  logic [PTR_W-1:0]   row_ptr;
  logic [BYTE_W-1:0]  held_high_byte;
  logic               high_byte_held;
  logic               bgr_order;
  logic               awake_state;
  logic               display_state;

  pixel_result_t expected_pixels [$];

  int  cycle_count  = 0;
  int  error_count  = 0;
  int  bytes_sent   = 0;
  bit  sender_burst = 1'b0;

  task automatic reset_decoder_state();
    current_command  = CMD_NONE;
    parameters_taken = '0;
    column_window    = {16'd0, 16'(PANEL_COLUMNS - 1)};
    row_window       = {16'd0, 16'(PANEL_ROWS - 1)};
    column_ptr       = '0;
    row_ptr          = '0;
    held_high_byte   = '0;
    high_byte_held   = 1'b0;
    bgr_order        = 1'b0;
    awake_state      = 1'b0;
    display_state    = 1'b0;
  endtask

  // Applies one accepted byte to the bench's decoder state and returns the
  // pixel transaction that the byte should produce.
  task automatic decode_link_byte(input logic is_command, input logic [BYTE_W-1:0] b,
                                  output pixel_result_t r);
    logic [COLOR_W-1:0] colour;
    r = '0;
    if (is_command) begin
      current_command  = b;
      parameters_taken = '0;
      high_byte_held   = 1'b0;
      case (b)
        CMD_MEMORY_WRITE: begin
          column_ptr = column_window[31:16];
          row_ptr    = row_window[31:16];
        end
        CMD_SLEEP_OUT:  awake_state   = 1'b1;
        CMD_DISPLAY_ON: display_state = 1'b1;
        default: ;
      endcase
    end else begin
      case (current_command)
        CMD_COLUMN_SET: begin
          if (parameters_taken < WINDOW_BYTES) begin
            column_window[31 - 8 * int'(parameters_taken) -: 8] = b;
            parameters_taken++;
          end
        end
        CMD_ROW_SET: begin
          if (parameters_taken < WINDOW_BYTES) begin
            row_window[31 - 8 * int'(parameters_taken) -: 8] = b;
            parameters_taken++;
          end
        end
        CMD_MADCTL: begin
          // Only the first parameter byte counts.
          if (parameters_taken == '0) begin
            bgr_order        = b[MADCTL_BGR_BIT];
            parameters_taken = INDEX_W'(1);
          end
        end
        CMD_MEMORY_WRITE: begin
          if (!high_byte_held) begin
            held_high_byte = b;
            high_byte_held = 1'b1;
          end else begin
            high_byte_held = 1'b0;
            colour = {held_high_byte, b};
            if (bgr_order) colour = {colour[4:0], colour[10:5], colour[15:11]};
            if (column_ptr < PANEL_COLUMNS && row_ptr < PANEL_ROWS) begin
              r.write_valid = 1'b1;
              r.column      = column_ptr[COLUMN_W-1:0];
              r.row         = row_ptr[ROW_W-1:0];
              r.pixel_color = colour;
            end
            // The pointer moves on whether or not the pixel was stored.
            if (column_ptr >= column_window[15:0]) begin
              column_ptr = column_window[31:16];
              if (row_ptr >= row_window[15:0]) row_ptr = row_window[31:16];
              else row_ptr++;
            end else begin
              column_ptr++;
            end
          end
        end
        default: ;
      endcase
    end
    r.awake           = awake_state;
    r.display_enabled = display_state;
  endtask

  task automatic flag_mismatch(input string msg);
    $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // Link side. A random gap comes before each byte unless the sender is in
  // a burst. Valid stays high from one transaction to the next when there is
  // no gap, so that it gets only one assignment in any time step. The byte
  // is passed to the decoder at the edge where it is accepted.
  // ---------------------------------------------------------------------
  task automatic send_link_byte(input logic is_command, input logic [BYTE_W-1:0] b,
                                input logic typed, input pixel_result_t typed_result);
    int gap;
    pixel_result_t predicted;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      if (link.valid) link.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    link.valid      <= 1'b1;
    link.command    <= is_command;
    link.byte_value <= b;
    @(posedge clk);
    while (!link.ready) @(posedge clk);
    decode_link_byte(is_command, b, predicted);
    expected_pixels.push_back(typed ? typed_result : predicted);
    bytes_sent++;
    if ($urandom_range(0, 63) == 0) sender_burst = !sender_burst;
  endtask

  task automatic send_random_byte(input logic is_command, input logic [BYTE_W-1:0] b);
    send_link_byte(is_command, b, 1'b0, '0);
  endtask

  // Withdraws valid and waits until every transaction owed has come back.
  // At least one edge always passes, so that the next assignment to valid
  // falls in a later time step.
  task automatic wait_for_results();
    link.valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  // A window coordinate, biased towards the panel but reaching its edges,
  // just beyond them, and the far end of the 16-bit range.
  function automatic logic [15:0] pick_coordinate(input int limit);
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'(limit - 1);
      2:       return 16'(limit + $urandom_range(0, 3));
      3:       return 16'hFFFF;
      4:       return 16'($urandom);
      default: return 16'($urandom_range(0, limit - 1));
    endcase
  endfunction

  // One command followed by its parameter bytes. Most sequences are well
  // formed, so that windows are set and filled. A minority are cut short,
  // overlong, or plain noise.
  task automatic send_random_sequence();
    int kind;
    int count;
    int limit;
    logic [15:0] start;
    logic [15:0] stop;
    logic [31:0] window_bytes;
    logic [BYTE_W-1:0] opcode;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      opcode = (kind < 15) ? CMD_COLUMN_SET : CMD_ROW_SET;
      limit  = (kind < 15) ? PANEL_COLUMNS : PANEL_ROWS;
      start  = pick_coordinate(limit);
      case ($urandom_range(0, 7))
        0:       stop = pick_coordinate(limit);
        1:       stop = start - 16'd1;
        default: stop = start + 16'($urandom_range(0, 4));
      endcase
      window_bytes = {start, stop};
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 4;
      send_random_byte(AS_COMMAND, opcode);
      for (int i = 0; i < count; i++)
        send_random_byte(AS_DATA, (i < 4) ? window_bytes[31 - 8 * i -: 8] : 8'($urandom));
    end else if (kind < 65) begin
      // Pixel data, now and then with a stray high byte left over at the end.
      count = 2 * $urandom_range(1, 24) + (($urandom_range(0, 9) == 0) ? 1 : 0);
      send_random_byte(AS_COMMAND, CMD_MEMORY_WRITE);
      repeat (count) send_random_byte(AS_DATA, 8'($urandom));
    end else if (kind < 73) begin
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1;
      send_random_byte(AS_COMMAND, CMD_MADCTL);
      repeat (count) send_random_byte(AS_DATA, 8'($urandom));
    end else if (kind < 78) begin
      send_random_byte(AS_COMMAND, $urandom_range(0, 1) ? CMD_SLEEP_OUT : CMD_DISPLAY_ON);
      repeat ($urandom_range(0, 2)) send_random_byte(AS_DATA, 8'($urandom));
    end else if (kind < 83) begin
      send_random_byte(AS_COMMAND, CMD_COLMOD);
      repeat ($urandom_range(0, 2))
        send_random_byte(AS_DATA, $urandom_range(0, 1) ? 8'h55 : 8'($urandom));
    end else if (kind < 92) begin
      // An arbitrary command byte, with a few data bytes that may follow it.
      send_random_byte(AS_COMMAND, $urandom_range(0, 3) ? 8'($urandom) : CMD_NONE);
      repeat ($urandom_range(0, 3)) send_random_byte(AS_DATA, 8'($urandom));
    end else begin
      // Stray data bytes, landing on whatever command happens to be active.
      repeat ($urandom_range(1, 3)) send_random_byte(AS_DATA, 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------
  // Pixel side. Ready drops for a random number of cycles before each
  // transaction, except during bursts. Once, after HOLD_AFTER results, it
  // stays low for a long hold whilst the sender carries on offering bytes.
  // ---------------------------------------------------------------------
  initial begin
    int stall;
    int results_seen;
    bit held_once;
    bit receiver_burst;
    pixel_result_t want;
    results_seen   = 0;
    held_once      = 1'b0;
    receiver_burst = 1'b0;
    pixel.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_once && results_seen == HOLD_AFTER) begin
        held_once = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = receiver_burst ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        pixel.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pixel.ready <= 1'b1;
      @(posedge clk);
      while (!pixel.valid) @(posedge clk);
      if (expected_pixels.size() == 0) begin
        flag_mismatch("pixel transaction with no byte outstanding");
      end else begin
        want = expected_pixels.pop_front();
        compare_field("write_valid", 16'(pixel.write_valid), 16'(want.write_valid));
        compare_field("column", 16'(pixel.column), 16'(want.column));
        compare_field("row", 16'(pixel.row), 16'(want.row));
        compare_field("pixel_color", pixel.pixel_color, want.pixel_color);
        compare_field("awake", 16'(pixel.awake), 16'(want.awake));
        compare_field("display_enabled", 16'(pixel.display_enabled),
                      16'(want.display_enabled));
      end
      results_seen++;
      if ($urandom_range(0, 63) == 0) receiver_burst = !receiver_burst;
    end
  end

  // Stops a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence: reset, the directed table, a pause until every result
  // has drained, the random phase with one further drain half-way through,
  // a last drain and finally the settling time.
  // ---------------------------------------------------------------------
  initial begin
    bit paused_midway;
    paused_midway = 1'b0;
    rst             <= 1'b1;
    link.valid      <= 1'b0;
    link.command    <= 1'b0;
    link.byte_value <= '0;
    reset_decoder_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_link_byte(DIRECTED[i].command, DIRECTED[i].value, DIRECTED[i].typed,
                     DIRECTED[i].result);
    wait_for_results();

    while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
      send_random_sequence();
      if (!paused_midway && bytes_sent >= DIRECTED_ROWS + RANDOM_BYTES / 2) begin
        paused_midway = 1'b1;
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
